// ===== sv/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the stable minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned PRIO_WIDTH_DEF = 16;

  // Request kinds carried on s_axis_tuser
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic enq;  // insert the new entry at its sorted place
    logic deq;  // shift every entry one cell toward the front
  } smpq_op_t;

endpackage

// ===== sv/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds an entry, flags whether the new entry
// sorts at or before this slot, and takes data from a neighbor on update.
// ----------------------------------------------------------------------------
module smpq_cell #(
  parameter int unsigned DEPTH      = smpq_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = smpq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = smpq_pkg::PRIO_WIDTH_DEF,
  parameter int unsigned INDEX      = 0
) (
  input  logic                          clk_i,
  input  smpq_pkg::smpq_op_t            op_i,
  input  logic [$clog2(DEPTH+1)-1:0]    count_i,
  input  logic [ELEM_WIDTH-1:0]         new_value_i,
  input  logic [PRIO_WIDTH-1:0]         new_prio_i,
  input  logic                          left_go_i,
  input  logic [ELEM_WIDTH-1:0]         left_value_i,
  input  logic [PRIO_WIDTH-1:0]         left_prio_i,
  input  logic [ELEM_WIDTH-1:0]         right_value_i,
  input  logic [PRIO_WIDTH-1:0]         right_prio_i,
  output logic                          go_o,
  output logic [ELEM_WIDTH-1:0]         value_o,
  output logic [PRIO_WIDTH-1:0]         prio_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [ELEM_WIDTH-1:0] value_q, value_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;
  logic                  occupied;

  assign occupied = (IDX < count_i);
  // Entries with equal priority stay ahead of the new one
  assign go_o     = !(occupied && (prio_q <= new_prio_i));

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (op_i.enq) begin
      if (left_go_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else if (go_o) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (op_i.deq) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ===== sv/stable_min_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core
// Bounded priority queue kept sorted in a chain of cells, smallest priority
// at the front, first in first out among equal priorities.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake                | Content
//  s_axis   | in  | s_axis_tvalid/tready     | tuser: kind; tdata: elem_value, prio
//  m_axis   | out | m_axis_tvalid/tready     | tdata: front_value, front_prio,
//           |     |                          |        count, is_empty, overflow,
//           |     |                          |        underflow
//
// One word per cycle while the receiver takes each result: every cell compares its
// priority with the new entry in parallel and the chain shifts in the same cycle,
// so a result appears in the cycle after its word is accepted. The result register
// holds until taken; a new word is accepted in the cycle the result is taken. Reset
// empties the queue at once. Entry storage has no reset.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_core #(
  parameter int unsigned DEPTH      = smpq_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = smpq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = smpq_pkg::PRIO_WIDTH_DEF,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
  localparam int unsigned IN_W      = ELEM_WIDTH + PRIO_WIDTH,
  localparam int unsigned IN_TD_W   = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ELEM_WIDTH + PRIO_WIDTH + CNT_W + 3,
  localparam int unsigned OUT_TD_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_TD_W-1:0]  s_axis_tdata,  // elem_value, prio (low to high)
  input  logic                s_axis_tuser,  // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_TD_W-1:0] m_axis_tdata   // front_value, front_prio, count,
                                             // is_empty, overflow, underflow
);

  logic [ELEM_WIDTH-1:0] new_value;
  logic [PRIO_WIDTH-1:0] new_prio;
  logic                  accept;
  logic                  full, empty;
  smpq_pkg::smpq_op_t    op;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             ovf_q, unf_q;

  logic [DEPTH-1:0]      go;
  logic [ELEM_WIDTH-1:0] value [DEPTH];
  logic [PRIO_WIDTH-1:0] prio  [DEPTH];

  assign new_value = s_axis_tdata[ELEM_WIDTH-1:0];
  assign new_prio  = s_axis_tdata[IN_W-1:ELEM_WIDTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Drop a full enqueue and an empty dequeue: the chain holds
  assign op.enq = accept && (s_axis_tuser == smpq_pkg::KIND_ENQ) && !full;
  assign op.deq = accept && (s_axis_tuser == smpq_pkg::KIND_DEQ) && !empty;

  always_comb begin
    count_d = count_q;
    if (op.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (op.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  left_go;
    logic [ELEM_WIDTH-1:0] left_value, right_value;
    logic [PRIO_WIDTH-1:0] left_prio, right_prio;

    if (i == 0) begin : g_head
      assign left_go    = 1'b0;
      assign left_value = new_value;
      assign left_prio  = new_prio;
    end else begin : g_body
      assign left_go    = go[i-1];
      assign left_value = value[i-1];
      assign left_prio  = prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // Last slot becomes unoccupied on dequeue; its content is not read
      assign right_value = value[i];
      assign right_prio  = prio[i];
    end else begin : g_mid
      assign right_value = value[i+1];
      assign right_prio  = prio[i+1];
    end

    smpq_cell #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .count_i       (count_q),
      .new_value_i   (new_value),
      .new_prio_i    (new_prio),
      .left_go_i     (left_go),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .go_o          (go[i]),
      .value_o       (value[i]),
      .prio_o        (prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ovf_q <= (s_axis_tuser == smpq_pkg::KIND_ENQ) && full;
      unf_q <= (s_axis_tuser == smpq_pkg::KIND_DEQ) && empty;
    end
  end

  // Chain and count change only on accept, so they hold the result until taken
  logic [ELEM_WIDTH-1:0] front_value;
  logic [PRIO_WIDTH-1:0] front_prio;

  assign front_value = empty ? '0 : value[0];
  assign front_prio  = empty ? '0 : prio[0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TD_W'({unf_q, ovf_q, empty, count_q, front_prio, front_value});

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stable_min_priority_queue_core: words go in on the
// slave stream, every accepted word is run through a sorted-array model of
// the queue, and each front report on the master stream is compared field by
// field with the oldest predicted report. Directed words cover empty, full,
// tie ordering and field extremes; random bursts swing the fill level between
// empty and full under several sender/receiver idle mixes and a long hold.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = smpq_pkg::DEPTH_DEF;
  localparam int unsigned ELEM_W     = smpq_pkg::ELEM_WIDTH_DEF;
  localparam int unsigned PRIO_W     = smpq_pkg::PRIO_WIDTH_DEF;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IN_TD_W    = ((ELEM_W + PRIO_W + 7) / 8) * 8;
  localparam int unsigned OUT_TD_W   = ((ELEM_W + PRIO_W + CNT_W + 3 + 7) / 8) * 8;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_PRINTS  = 40;

  typedef struct packed {
    logic              kind;
    logic [PRIO_W-1:0] prio;
    logic [ELEM_W-1:0] value;
  } word_t;

  // Lowest bits first: front_value, front_prio, count, is_empty, overflow, underflow
  typedef struct packed {
    logic              underflow;
    logic              overflow;
    logic              is_empty;
    logic [CNT_W-1:0]  count;
    logic [PRIO_W-1:0] front_prio;
    logic [ELEM_W-1:0] front_value;
  } front_t;

  typedef enum {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_TD_W-1:0]  s_axis_tdata  = '0;  // elem_value, prio
  logic                s_axis_tuser  = 1'b0; // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TD_W-1:0] m_axis_tdata;  // front_value, front_prio, count,
                                      // is_empty, overflow, underflow

  stable_min_priority_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  word_t       pending_words[$];
  front_t      expected_fronts[$];
  phase_e      phase = PH_FREE;
  logic        word_taken = 1'b0;
  int unsigned hold_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_in = 0, results_out = 0;
  int unsigned drops_full = 0, refused_empty = 0, full_reports = 0;

  // Queue model: sorted slots, front at index 0
  logic [ELEM_W-1:0] model_value[DEPTH];
  logic [PRIO_W-1:0] model_prio[DEPTH];
  int unsigned       model_count = 0;

  function automatic front_t predict_front(input word_t w);
    front_t      res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    if (w.kind == smpq_pkg::KIND_ENQ) begin
      if (model_count >= DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        // Go behind every entry of equal priority
        pos = 0;
        while (pos < model_count && model_prio[pos] <= w.prio) pos++;
        for (i = model_count; i > pos; i--) begin
          model_value[i] = model_value[i-1];
          model_prio[i]  = model_prio[i-1];
        end
        model_value[pos] = w.value;
        model_prio[pos]  = w.prio;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.underflow = 1'b1;
      end else begin
        for (i = 0; i + 1 < model_count; i++) begin
          model_value[i] = model_value[i+1];
          model_prio[i]  = model_prio[i+1];
        end
        model_count--;
      end
    end
    res.count    = CNT_W'(model_count);
    res.is_empty = (model_count == 0);
    if (model_count != 0) begin
      res.front_value = model_value[0];
      res.front_prio  = model_prio[0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drive new words at the falling edge
  always @(negedge clk_i) begin : drive_words
    word_t w;
    int unsigned idle_pct;
    idle_pct = (phase == PH_SEND_IDLE) ? 55 : (phase == PH_BOTH) ? 8 : 0;
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.kind;
        s_axis_tdata  <= IN_TD_W'({w.prio, w.value});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side: one long hold in the hold phase, random stalls otherwise
  always @(negedge clk_i) begin : drive_ready
    int unsigned stall_pct;
    stall_pct = (phase == PH_RECV_STALL) ? 55 : (phase == PH_BOTH) ? 8 : 0;
    if (rst_ni) begin
      if (phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
        m_axis_tready <= 1'b0;
        hold_count    <= hold_count + 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Sample both streams at the rising edge; check results before predicting
  always @(posedge clk_i) begin : watch_streams
    word_t  w;
    front_t got;
    front_t want;
    if (rst_ni) begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(front_t)-1:0];
        results_out++;
        if (expected_fronts.size() == 0) begin
          report_mismatch("result with nothing pending", got, 0);
        end else begin
          want = expected_fronts.pop_front();
          if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
          if (got.front_prio !== want.front_prio)
            report_mismatch("front_prio", got.front_prio, want.front_prio);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
          if (got.underflow !== want.underflow)
            report_mismatch("underflow", got.underflow, want.underflow);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        w.kind = s_axis_tuser;
        {w.prio, w.value} = s_axis_tdata[$bits(w.prio)+$bits(w.value)-1:0];
        want = predict_front(w);
        expected_fronts.push_back(want);
        words_in++;
        if (want.overflow) drops_full++;
        if (want.underflow) refused_empty++;
        if (want.count == DEPTH) full_reports++;
      end
    end
  end

  task automatic add_word(input logic kind, input logic [ELEM_W-1:0] value,
                          input logic [PRIO_W-1:0] prio);
    word_t w;
    w.kind  = kind;
    w.value = value;
    w.prio  = prio;
    pending_words.push_back(w);
  endtask

  function automatic word_t random_word(input int unsigned enq_pct);
    word_t w;
    w.kind = ($urandom_range(99) < enq_pct) ? smpq_pkg::KIND_ENQ : smpq_pkg::KIND_DEQ;
    case ($urandom_range(7))
      0:       w.value = '0;
      1:       w.value = '1;
      default: w.value = $urandom;
    endcase
    case ($urandom_range(3))
      0:       w.prio = PRIO_W'($urandom_range(3));  // crowd ties
      1:       w.prio = $urandom_range(1) ? '1 : '0;
      default: w.prio = PRIO_W'($urandom);
    endcase
    return w;
  endfunction

  // Bursts lean toward enqueue or dequeue so the fill level sweeps both ends
  task automatic add_random_words(input int unsigned n);
    int unsigned enq_pct;
    int unsigned k;
    enq_pct = 50;
    for (k = 0; k < n; k++) begin
      if (k % 24 == 0) begin
        case ($urandom_range(3))
          0:       enq_pct = 25;
          1:       enq_pct = 50;
          2:       enq_pct = 75;
          default: enq_pct = 90;
        endcase
      end
      pending_words.push_back(random_word(enq_pct));
    end
  endtask

  task automatic wait_drained();
    int unsigned n;
    while (pending_words.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    for (n = 0; n < 2000 && expected_fronts.size() != 0; n++) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned i;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty dequeue, extremes, ties, fill to full, overflow, partial drain
    add_word(smpq_pkg::KIND_DEQ, 32'h0000_0000, 16'h0000);
    add_word(smpq_pkg::KIND_ENQ, 32'hffff_ffff, 16'hffff);
    add_word(smpq_pkg::KIND_ENQ, 32'h0000_0000, 16'h0000);
    add_word(smpq_pkg::KIND_ENQ, 32'h0000_000a, 16'h0005);
    add_word(smpq_pkg::KIND_ENQ, 32'h0000_000b, 16'h0005);
    add_word(smpq_pkg::KIND_ENQ, 32'h0000_000c, 16'h0005);
    for (i = 0; i < DEPTH - 5; i++)
      add_word(smpq_pkg::KIND_ENQ, 32'h0000_0100 + i, i[0] ? 16'h0005 : 16'hfffe);
    add_word(smpq_pkg::KIND_ENQ, 32'h5a5a_a5a5, 16'h0000);
    for (i = 0; i < 6; i++)
      add_word(smpq_pkg::KIND_DEQ, 32'hffff_ffff, 16'hffff);
    wait_drained();

    phase = PH_FREE;
    add_random_words(200);
    wait_drained();
    phase = PH_SEND_IDLE;
    add_random_words(200);
    wait_drained();
    phase = PH_RECV_STALL;
    add_random_words(200);
    wait_drained();
    phase = PH_BOTH;
    add_random_words(150);
    wait_drained();
    phase = PH_HOLD;
    add_random_words(80);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (expected_fronts.size() != 0)
      report_mismatch("results never delivered", expected_fronts.size(), 0);

    $display("Covered %0d words and %0d reports under four idle mixes and a long hold.",
             words_in, results_out);
    $display("Full-queue drops %0d, empty-queue dequeues %0d, reports at full depth %0d.",
             drops_full, refused_empty, full_reports);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
